@@ hdl/ucmr_pkg.sv @@
// Package for the UART command motor/relay controller.
// Holds the transaction structs, state encodings and command byte codes.
// No dependencies.
package ucmr_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_FAST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_SLOW = 1'b1;

    localparam logic [7:0] ARM_FAST_RESET = 8'd150;
    localparam logic [7:0] ARM_SLOW_RESET = 8'd45;
    localparam logic [7:0] SPEED_MAX      = 8'd255;

    // Command and number byte codes (ASCII)
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D_UP  = 8'h44;
    localparam logic [7:0] CH_D_LO  = 8'h64;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_G_UP  = 8'h47;
    localparam logic [7:0] CH_G_LO  = 8'h67;
    localparam logic [7:0] CH_H_UP  = 8'h48;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LF    = 8'h0a;

    localparam logic [3:0] RELAY_RESET = 4'hf;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SKIP = 2'd1,
        PH_NUM  = 2'd2
    } t_parse_phase;

    typedef enum logic [2:0] {
        ARM_STOP       = 3'd0,
        ARM_BACK_FAST  = 3'd1,
        ARM_BACK_SLOW  = 3'd2,
        ARM_FRONT_FAST = 3'd3,
        ARM_FRONT_SLOW = 3'd4
    } t_arm_mode;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
        logic       box_front_hit;
        logic       box_back_hit;
        logic       arm_back_hit;
        logic       arm_front_hit;
    } t_in_item;

    typedef struct packed {
        logic [3:0] relay_levels;
        logic [7:0] box_reverse_duty;
        logic [7:0] box_forward_duty;
        logic [7:0] arm_back_duty;
        logic [7:0] arm_front_duty;
    } t_out_item;

    // Control state as seen by the drive stage; box speed is sign/magnitude
    typedef struct packed {
        logic [3:0] relay_bits;
        t_arm_mode  arm_mode;
        logic       box_neg;
        logic [7:0] box_mag;
    } t_ctrl_state;

    typedef struct packed {
        logic [7:0] arm_fast_speed;
        logic [7:0] arm_slow_speed;
    } t_arm_cfg;

endpackage

@@ hdl/ucmr_cfg_regs.sv @@
// Configuration registers of the controller (arm fast and slow duty).
// Depends on ucmr_pkg.
module ucmr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [ucmr_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [7:0]                    i_wr_data,
    output ucmr_pkg::t_arm_cfg            o_cfg
);
    import ucmr_pkg::*;

    logic [7:0] r_fast;
    logic [7:0] r_slow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= ARM_FAST_RESET;
            r_slow <= ARM_SLOW_RESET;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_ARM_FAST: r_fast <= i_wr_data;
                CFG_ARM_SLOW: r_slow <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.arm_fast_speed = r_fast;
    assign o_cfg.arm_slow_speed = r_slow;

endmodule

@@ hdl/ucmr_cmd_core.sv @@
// Command decoder and number parser; holds relay, arm and box speed state.
// Presents the state after the current transaction. Depends on ucmr_pkg.
module ucmr_cmd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  ucmr_pkg::t_in_item    i_item,
    output ucmr_pkg::t_ctrl_state o_state
);
    import ucmr_pkg::*;

    t_parse_phase r_phase,   n_phase;
    logic [3:0]   r_relay,   n_relay;
    t_arm_mode    r_arm,     n_arm;
    logic         r_box_neg, n_box_neg;
    logic [7:0]   r_box_mag, n_box_mag;
    logic [7:0]   r_acc,     n_acc;
    logic         r_neg,     n_neg;

    logic [7:0]  b;
    logic        has_byte;
    logic        is_digit;
    logic        is_minus;
    logic        is_num;
    logic        num_take;
    logic        num_end;
    logic        cmd_en;
    logic [11:0] acc_x10;

    assign b        = i_item.rx_byte;
    assign has_byte = i_item.byte_valid;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_minus = (b == CH_MINUS);
    assign is_num   = is_digit || is_minus;

    assign num_take = has_byte && is_num && (r_phase == PH_SKIP || r_phase == PH_NUM);
    assign num_end  = has_byte && !is_num && (r_phase == PH_NUM);
    // terminator other than newline is also run as a command
    assign cmd_en   = has_byte && ((r_phase == PH_IDLE) || (num_end && (b != CH_LF)));

    // acc * 10 + digit, at most 2559
    assign acc_x10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {8'd0, b[3:0]};

    // parser phase
    always_comb begin
        n_phase = r_phase;
        if (has_byte) begin
            unique case (r_phase)
                PH_IDLE: if (b == CH_X) n_phase = PH_SKIP;
                PH_SKIP: if (is_num) n_phase = PH_NUM;
                PH_NUM: begin
                    if (!is_num) n_phase = (b == CH_X) ? PH_SKIP : PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // relays, arm, box speed and number accumulator
    always_comb begin
        n_relay   = r_relay;
        n_arm     = r_arm;
        n_box_neg = r_box_neg;
        n_box_mag = r_box_mag;
        n_acc     = r_acc;
        n_neg     = r_neg;

        if (num_take) begin
            if (is_minus) begin
                n_neg = 1'b1;
            end else begin
                n_acc = (acc_x10 > {4'd0, SPEED_MAX}) ? SPEED_MAX : acc_x10[7:0];
            end
        end

        if (num_end) begin
            n_box_neg = r_neg;
            n_box_mag = r_acc;
            n_acc     = '0;
            n_neg     = 1'b0;
        end

        if (cmd_en) begin
            unique case (b)
                CH_A:    n_relay = r_relay ^ 4'b0010;
                CH_B:    n_relay = r_relay ^ 4'b0100;
                CH_C:    n_relay = r_relay ^ 4'b1000;
                CH_D_UP: n_relay = r_relay & 4'b1110;
                CH_D_LO: n_relay = r_relay | 4'b0001;
                CH_S: begin
                    n_box_neg = 1'b0;
                    n_box_mag = '0;
                    n_arm     = ARM_STOP;
                end
                CH_X: begin
                    n_acc = '0;
                    n_neg = 1'b0;
                end
                CH_G_UP: n_arm = ARM_BACK_FAST;
                CH_G_LO: n_arm = ARM_BACK_SLOW;
                CH_H_UP: n_arm = ARM_FRONT_FAST;
                CH_H_LO: n_arm = ARM_FRONT_SLOW;
                CH_V:    n_arm = ARM_STOP;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_relay   <= RELAY_RESET;
            r_arm     <= ARM_STOP;
            r_box_neg <= 1'b0;
            r_box_mag <= '0;
            r_acc     <= '0;
            r_neg     <= 1'b0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_relay   <= n_relay;
            r_arm     <= n_arm;
            r_box_neg <= n_box_neg;
            r_box_mag <= n_box_mag;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
        end
    end

    assign o_state.relay_bits = n_relay;
    assign o_state.arm_mode   = n_arm;
    assign o_state.box_neg    = n_box_neg;
    assign o_state.box_mag    = n_box_mag;

endmodule

@@ hdl/ucmr_drive.sv @@
// Drive duty and relay level calculation with limit switch interlock.
// Depends on ucmr_pkg.
module ucmr_drive (
    input  ucmr_pkg::t_ctrl_state i_state,
    input  ucmr_pkg::t_arm_cfg    i_cfg,
    input  ucmr_pkg::t_in_item    i_item,
    output ucmr_pkg::t_out_item   o_result
);
    import ucmr_pkg::*;

    logic       arm_back_sel;
    logic       arm_front_sel;
    logic       arm_fast;
    logic [7:0] arm_duty;

    assign arm_back_sel  = (i_state.arm_mode == ARM_BACK_FAST)
                        || (i_state.arm_mode == ARM_BACK_SLOW);
    assign arm_front_sel = (i_state.arm_mode == ARM_FRONT_FAST)
                        || (i_state.arm_mode == ARM_FRONT_SLOW);
    assign arm_fast      = (i_state.arm_mode == ARM_BACK_FAST)
                        || (i_state.arm_mode == ARM_FRONT_FAST);
    assign arm_duty      = arm_fast ? i_cfg.arm_fast_speed : i_cfg.arm_slow_speed;

    always_comb begin
        o_result.relay_levels     = i_state.relay_bits;
        // a zero magnitude gives zero duty either way
        o_result.box_reverse_duty = (i_state.box_neg && !i_item.box_back_hit)
                                  ? i_state.box_mag : 8'd0;
        o_result.box_forward_duty = (!i_state.box_neg && !i_item.box_front_hit)
                                  ? i_state.box_mag : 8'd0;
        o_result.arm_back_duty    = (arm_back_sel && !i_item.arm_back_hit)
                                  ? arm_duty : 8'd0;
        o_result.arm_front_duty   = (arm_front_sel && !i_item.arm_front_hit)
                                  ? arm_duty : 8'd0;
    end

endmodule

@@ hdl/uart_command_motor_relay_control.sv @@
// Top level of the UART command motor/relay controller.
// Depends on ucmr_pkg, ucmr_cfg_regs, ucmr_cmd_core and ucmr_drive.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one transaction per
//   sample: an optional received byte plus the four limit switch levels.
//   Output channel (o_out_valid / i_out_stall / o_out_item): exactly one
//   result per input transaction: relay pin levels and the four drive duties.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 = arm fast duty,
//   index 1 = arm slow duty. Always ready; write only while idle.
// Path: a transaction that is taken lands in the input register, is decoded
//   and then lands in the output register, which drives o_out_valid and
//   o_out_item.
// Throughput: one transaction per cycle while the output is not stalled; the
//   whole decode, parse step (acc*10 + digit with saturation) and interlock
//   is one combinational pass between the input and output registers.
// Reset (synchronous, active low): relays off (all ones), arm stopped, box
//   speed zero, parser idle, duties back to 150/45, both channels empty.
// Stall: when the output register is full and stalled, the input register
//   holds and o_in_stall rises only if the input register is also occupied,
//   so one more transaction is still taken while a result waits.
module uart_command_motor_relay_control (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transactions
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ucmr_pkg::t_in_item             i_in_item,
    // result transactions
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ucmr_pkg::t_out_item            o_out_item,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ucmr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import ucmr_pkg::*;

    // input register
    logic       r_in_valid;
    t_in_item   r_in_item;
    // output register
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic        out_free;   // output register can take a result this cycle
    logic        advance;    // input register moves to the output register
    logic        in_take;    // new transaction accepted
    t_arm_cfg    arm_cfg;
    t_ctrl_state ctrl_state;
    t_out_item   result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    ucmr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (arm_cfg)
    );

    // state updates only when the item actually moves on
    ucmr_cmd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_state   (ctrl_state)
    );

    ucmr_drive u_drive (
        .i_state  (ctrl_state),
        .i_cfg    (arm_cfg),
        .i_item   (r_in_item),
        .o_result (result)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for uart_command_motor_relay_control.
// Depends on ucmr_pkg and the RTL top level. Holds its own predictor of the relay
// levels and drive duties in a small scoreboard class.
module tb;
    import ucmr_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int QUIET_LIMIT = 5000;   // cycles with no transaction of any kind
    localparam int PHASE_ITEMS = 270;    // byte-carrying items per random phase

    // ------------------------------------------------------------------
    // Scoreboard: tracks the command parser state and predicts the drive
    // levels for each accepted input transaction, then checks the results
    // in order.
    // ------------------------------------------------------------------
    class drive_level_scoreboard;
        t_out_item    pending_levels[$];
        int           mismatch_count;

        logic [3:0]   relays;
        t_arm_mode    arm;
        logic         box_neg;      // box speed as sign and magnitude
        logic [7:0]   box_mag;
        t_parse_phase phase;
        logic [7:0]   acc;
        logic         acc_neg;
        logic [7:0]   fast_duty;
        logic [7:0]   slow_duty;

        function new();
            relays         = RELAY_RESET;
            arm            = ARM_STOP;
            box_neg        = 1'b0;
            box_mag        = 8'd0;
            phase          = PH_IDLE;
            acc            = 8'd0;
            acc_neg        = 1'b0;
            fast_duty      = ARM_FAST_RESET;
            slow_duty      = ARM_SLOW_RESET;
            mismatch_count = 0;
        endfunction

        function void write_speed(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_ARM_FAST) begin
                fast_duty = data;
            end else begin
                slow_duty = data;
            end
        endfunction

        function bit is_number_byte(logic [7:0] b);
            return (b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS;
        endfunction

        // Minus flags the number anywhere; digits accumulate, clamped at 255
        function void take_number_byte(logic [7:0] b);
            int v;
            if (b == CH_MINUS) begin
                acc_neg = 1'b1;
            end else begin
                v = int'(acc) * 10 + int'(b) - int'(CH_ZERO);
                acc = (v > int'(SPEED_MAX)) ? SPEED_MAX : v[7:0];
            end
        endfunction

        function void run_command(logic [7:0] b);
            case (b)
                CH_A:    relays[1] = ~relays[1];
                CH_B:    relays[2] = ~relays[2];
                CH_C:    relays[3] = ~relays[3];
                CH_D_UP: relays[0] = 1'b0;
                CH_D_LO: relays[0] = 1'b1;
                CH_S: begin
                    box_neg = 1'b0;
                    box_mag = 8'd0;
                    arm     = ARM_STOP;
                end
                CH_X: begin
                    phase   = PH_SKIP;
                    acc     = 8'd0;
                    acc_neg = 1'b0;
                end
                CH_G_UP: arm = ARM_BACK_FAST;
                CH_G_LO: arm = ARM_BACK_SLOW;
                CH_H_UP: arm = ARM_FRONT_FAST;
                CH_H_LO: arm = ARM_FRONT_SLOW;
                CH_V:    arm = ARM_STOP;
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            if (phase == PH_SKIP) begin
                if (is_number_byte(b)) begin
                    phase = PH_NUM;
                    take_number_byte(b);
                end
                return;
            end
            if (phase == PH_NUM) begin
                if (is_number_byte(b)) begin
                    take_number_byte(b);
                    return;
                end
                // number ends; minus with no digits is plain zero
                box_mag = acc;
                box_neg = acc_neg && (acc != 8'd0);
                phase   = PH_IDLE;
                acc     = 8'd0;
                acc_neg = 1'b0;
                if (b == CH_LF) begin
                    return;
                end
            end
            run_command(b);
        endfunction

        function void note_input(t_in_item it);
            t_out_item lv;
            if (it.byte_valid) begin
                take_byte(it.rx_byte);
            end
            lv = '0;
            lv.relay_levels = relays;
            if (box_neg && !it.box_back_hit) begin
                lv.box_reverse_duty = box_mag;
            end else if (!box_neg && box_mag != 8'd0 && !it.box_front_hit) begin
                lv.box_forward_duty = box_mag;
            end
            case (arm)
                ARM_BACK_FAST:  if (!it.arm_back_hit) lv.arm_back_duty = fast_duty;
                ARM_BACK_SLOW:  if (!it.arm_back_hit) lv.arm_back_duty = slow_duty;
                ARM_FRONT_FAST: if (!it.arm_front_hit) lv.arm_front_duty = fast_duty;
                ARM_FRONT_SLOW: if (!it.arm_front_hit) lv.arm_front_duty = slow_duty;
                default: ;
            endcase
            pending_levels.push_back(lv);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want) begin
                report($sformatf("%s got %0d, want %0d", name, got, want));
            end
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_levels.size() == 0) begin
                report($sformatf("result with nothing pending: %h", got));
                return;
            end
            want = pending_levels.pop_front();
            compare_field("relay_levels", got.relay_levels, want.relay_levels);
            compare_field("box_reverse_duty", got.box_reverse_duty, want.box_reverse_duty);
            compare_field("box_forward_duty", got.box_forward_duty, want.box_forward_duty);
            compare_field("arm_back_duty", got.arm_back_duty, want.arm_back_duty);
            compare_field("arm_front_duty", got.arm_front_duty, want.arm_front_duty);
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    uart_command_motor_relay_control uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    drive_level_scoreboard sb = new();

    int burst_left;   // transactions left before the sender may take a gap
    int quiet_cycles;

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the DUT
    // registers update. A result always belongs to an earlier transaction,
    // so results are checked before the new input is noted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit seen;
        seen = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_item);
                seen = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_input(i_in_item);
                seen = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_speed(i_cfg_index, i_cfg_data);
                seen = 1'b1;
            end
            if (seen) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: switches between free flow, coin flips, a
    // periodic 3-of-5 stall and long runs of stall and no stall.
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int span;
        int pat_cnt;
        i_out_stall = 1'b0;
        pat_cnt = 0;
        forever begin
            mode = $urandom_range(3);
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(negedge i_clk);
                pat_cnt++;
                case (mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = 1'($urandom_range(1));
                    2: i_out_stall = (pat_cnt % 5) < 3;
                    default: if ($urandom_range(15) == 0) i_out_stall = ~i_out_stall;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(bit bv, logic [7:0] b, logic [3:0] sw);
        t_in_item it;
        it.byte_valid    = bv;
        it.rx_byte       = b;
        it.box_front_hit = sw[3];
        it.box_back_hit  = sw[2];
        it.arm_back_hit  = sw[1];
        it.arm_front_hit = sw[0];
        return it;
    endfunction

    // Limit switches mostly released so the duties show up
    function automatic logic [3:0] rand_switches();
        logic [3:0] sw;
        for (int k = 0; k < 4; k++) begin
            sw[k] = ($urandom_range(3) == 0);
        end
        return sw;
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(11))
            0:  return CH_A;
            1:  return CH_B;
            2:  return CH_C;
            3:  return CH_D_UP;
            4:  return CH_D_LO;
            5:  return CH_S;
            6:  return CH_X;
            7:  return CH_G_UP;
            8:  return CH_G_LO;
            9:  return CH_H_UP;
            10: return CH_H_LO;
            default: return CH_V;
        endcase
    endfunction

    // One transaction, then possibly a gap once the burst runs out
    task automatic drive_item(t_in_item it);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        drive_item(make_item(1'b1, b, rand_switches()));
    endtask

    // Hold off until every expected result has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_levels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_speed(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly well-formed command and number sequences, some noise.
    // Returns once n byte-carrying transactions went out.
    task automatic run_random(int n);
        int count;
        int r;
        int len;
        logic [7:0] b;
        count = 0;
        while (count < n) begin
            r = $urandom_range(99);
            if (r < 35) begin
                send_byte(pick_command());
                count++;
            end else if (r < 75) begin
                send_byte(CH_X);
                count++;
                // dropped bytes before the number starts
                repeat ($urandom_range(2)) begin
                    do b = 8'($urandom_range(255)); while (sb.is_number_byte(b));
                    send_byte(b);
                    count++;
                end
                len = $urandom_range(1, 4);
                repeat (len) begin
                    if ($urandom_range(5) == 0) begin
                        b = CH_MINUS;
                    end else begin
                        b = CH_ZERO + 8'($urandom_range(9));
                    end
                    send_byte(b);
                    count++;
                end
                r = $urandom_range(9);
                if (r < 4) begin
                    send_byte(CH_LF);
                end else if (r < 8) begin
                    send_byte(pick_command());
                end else begin
                    send_byte(8'($urandom_range(255)));
                end
                count++;
            end else if (r < 90) begin
                send_byte(8'($urandom_range(255)));
                count++;
            end else begin
                // no byte: outputs follow the switches only
                drive_item(make_item(1'b0, 8'($urandom_range(255)), rand_switches()));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] fast_set;
        logic [7:0] slow_set;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_ARM_FAST;
        i_cfg_data   = 8'd0;
        burst_left   = 1;
        quiet_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every command, limit interlocks, saturation, minus
        // inside a number, minus alone, a command ending a number.
        drive_item(make_item(1'b1, CH_D_UP, 4'b0000));
        drive_item(make_item(1'b1, CH_A,    4'b0000));
        drive_item(make_item(1'b1, CH_B,    4'b1111));
        drive_item(make_item(1'b1, CH_C,    4'b0000));
        drive_item(make_item(1'b1, CH_D_LO, 4'b0000));
        drive_item(make_item(1'b1, CH_G_UP, 4'b0010));
        drive_item(make_item(1'b1, CH_G_LO, 4'b0000));
        drive_item(make_item(1'b1, CH_H_UP, 4'b0001));
        drive_item(make_item(1'b1, CH_H_LO, 4'b0000));
        drive_item(make_item(1'b1, CH_V,    4'b0000));
        drive_item(make_item(1'b1, CH_X,    4'b0000));
        drive_item(make_item(1'b1, 8'hff,   4'b0000));
        drive_item(make_item(1'b1, CH_NINE, 4'b0000));
        drive_item(make_item(1'b1, CH_NINE, 4'b0000));
        drive_item(make_item(1'b1, CH_NINE, 4'b0000));
        drive_item(make_item(1'b1, CH_LF,   4'b0000));
        drive_item(make_item(1'b0, 8'h00,   4'b1000));
        drive_item(make_item(1'b1, CH_X,    4'b0000));
        drive_item(make_item(1'b1, CH_ZERO, 4'b0000));
        drive_item(make_item(1'b1, CH_MINUS, 4'b0000));
        drive_item(make_item(1'b1, CH_NINE, 4'b0000));
        drive_item(make_item(1'b1, CH_H_UP, 4'b0000));
        drive_item(make_item(1'b0, 8'hff,   4'b0100));
        drive_item(make_item(1'b1, CH_X,    4'b0000));
        drive_item(make_item(1'b1, CH_MINUS, 4'b0000));
        drive_item(make_item(1'b1, 8'h00,   4'b0000));
        drive_item(make_item(1'b1, CH_S,    4'b0000));
        drain();

        // Random phases under different arm duty settings, extremes first
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin fast_set = 8'd255; slow_set = 8'd0;   end
                1: begin fast_set = 8'd0;   slow_set = 8'd255; end
                default: begin
                    fast_set = 8'($urandom_range(255));
                    slow_set = 8'($urandom_range(255));
                end
            endcase
            write_speed(CFG_ARM_FAST, fast_set);
            write_speed(CFG_ARM_SLOW, slow_set);
            run_random(PHASE_ITEMS);
            drain();
        end

        repeat (5) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_levels.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
